// ===== rtl/present24_key_schedule_defines.svh =====
// Assertion macros shared by the key schedule RTL.
`ifndef PRESENT24_KEY_SCHEDULE_DEFINES_SVH
`define PRESENT24_KEY_SCHEDULE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define PS24_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ps24 assertion failed");
// Checked at every edge, reset included.
`define PS24_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ps24 assertion failed");
`else
`define PS24_ASSERT(lbl, clk, rst, prop)
`define PS24_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/ps24_pkg.sv =====
// Package: constants, types and the S-box of the key schedule.
`default_nettype none
package ps24_pkg;

  localparam int NUM_SUBKEYS  = 11;
  localparam int KEY_W        = 80;
  localparam int MASTER_W     = 24;
  localparam int SUBKEY_W     = 24;
  localparam int SUBKEY_LSB   = 16;
  localparam int ROUND_W      = 5;
  localparam int ROT_RIGHT    = 19;
  localparam int MIX_LSB      = 15;
  localparam int MIX_W        = 8;

  // Per-cell control, shared by every bit cell of the key register.
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ps24_if.sv =====
// Channel interfaces: master key in, round subkey out.
`default_nettype none
interface ps24_key_if;
  logic                              valid;
  logic                              ready;
  logic [ps24_pkg::MASTER_W-1:0]     master_key;

  modport source (output valid, output master_key, input ready);
  modport sink   (input valid, input master_key, output ready);
endinterface

interface ps24_sub_if;
  logic                              valid;
  logic                              ready;
  logic [ps24_pkg::SUBKEY_W-1:0]     subkey;
  logic [ps24_pkg::ROUND_W-1:0]      round_number;
  logic                              last_subkey;

  modport source (output valid, output subkey, output round_number,
                  output last_subkey, input ready);
  modport sink   (input valid, input subkey, input round_number,
                  input last_subkey, output ready);
endinterface
`default_nettype wire

// ===== rtl/ps24_cell.sv =====
// One bit cell of the key register: load from the master key or take the next round bit.
`default_nettype none
module ps24_cell (
  input  wire logic                 clk,
  input  wire ps24_pkg::cell_ctrl_t ctrl,
  input  wire logic                 load_bit,
  input  wire logic                 step_bit,
  output logic                      bit_q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bit_q <= load_bit;
    end else if (ctrl.step) begin
      bit_q <= step_bit;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/present24_key_schedule.sv =====
// Top level of the 24-bit PRESENT-style key schedule.
// Takes one 24-bit master key per transaction and emits NUM_SUBKEYS (11) round
// subkeys from it, one per cycle while the output side accepts, the last one
// flagged by last_subkey. A new master key is taken in the same cycle as the
// last subkey of the previous one leaves the key register, so keys never overlap;
// the master key rate is set by the single 80-bit key register (a row of bit
// cells) advancing one round per emitted subkey. Output is registered; there is
// no reset-time clearing pass.
`default_nettype none
module present24_key_schedule (
  input  wire logic        clk,
  input  wire logic        rst,
  ps24_key_if.sink         key_in,
  ps24_sub_if.source       sub_out
);

  localparam int KW = ps24_pkg::KEY_W;
  localparam logic [ps24_pkg::ROUND_W-1:0] LAST_CNT =
    ps24_pkg::ROUND_W'(ps24_pkg::NUM_SUBKEYS - 1);

  logic [KW-1:0]                   key_q;
  logic [KW-1:0]                   load_val;
  logic [KW-1:0]                   rot;
  logic [KW-1:0]                   step_val;
  logic                            busy;
  logic                            busy_next;
  logic [ps24_pkg::ROUND_W-1:0]    cnt;
  logic [ps24_pkg::ROUND_W-1:0]    cnt_next;
  logic                            emit;
  logic                            at_last;
  logic                            accept;
  logic                            out_valid;
  logic                            out_valid_next;
  logic [ps24_pkg::MIX_W-1:0]      mix;
  ps24_pkg::cell_ctrl_t            ctrl;

  assign at_last = (cnt == LAST_CNT);
  assign emit    = busy && (!out_valid || sub_out.ready);
  assign key_in.ready = !busy || (emit && at_last);
  assign accept  = key_in.valid && key_in.ready;

  assign ctrl = '{load: accept, step: emit};

  // Master key sits at the top of the register, the rest cleared.
  assign load_val = {key_in.master_key, (KW - ps24_pkg::MASTER_W)'(0)};

  // Rotate left by 61, substitute the top nibble, mix in the 1-based round.
  assign rot = {key_q[ps24_pkg::ROT_RIGHT-1:0], key_q[KW-1:ps24_pkg::ROT_RIGHT]};
  assign mix = ps24_pkg::MIX_W'(cnt) + ps24_pkg::MIX_W'(1);

  always_comb begin
    step_val = rot;
    step_val[KW-1:KW-4] = ps24_pkg::sbox(rot[KW-1:KW-4]);
    step_val[ps24_pkg::MIX_LSB +: ps24_pkg::MIX_W] =
      rot[ps24_pkg::MIX_LSB +: ps24_pkg::MIX_W] ^ mix;
  end

  for (genvar i = 0; i < KW; i++) begin : g_cell
    ps24_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_bit (load_val[i]),
      .step_bit (step_val[i]),
      .bit_q    (key_q[i])
    );
  end

  always_comb begin
    busy_next = busy;
    cnt_next  = cnt;
    if (emit) begin
      cnt_next = cnt + ps24_pkg::ROUND_W'(1);
      if (at_last) begin
        busy_next = 1'b0;
      end
    end
    // A new key overrides the drop at the end of the previous one.
    if (accept) begin
      busy_next = 1'b1;
      cnt_next  = '0;
    end
  end

  always_comb begin
    priority if (emit) begin
      out_valid_next = 1'b1;
    end else if (sub_out.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sub_out.subkey       <= key_q[ps24_pkg::SUBKEY_LSB +: ps24_pkg::SUBKEY_W];
      sub_out.round_number <= cnt;
      sub_out.last_subkey  <= at_last;
    end
  end

  assign sub_out.valid = out_valid;

`include "present24_key_schedule_defines.svh"

  `PS24_ASSERT(a_cnt_range, clk, rst, busy |-> (cnt <= LAST_CNT))
  `PS24_ASSERT(a_last_round, clk, rst,
               (out_valid && sub_out.last_subkey) |-> (sub_out.round_number == LAST_CNT))
  `PS24_ASSERT(a_keep_busy, clk, rst, (emit && !at_last) |=> busy)
  `PS24_ASSERT(a_accept_gap, clk, rst, (accept && busy) |-> (emit && at_last))
  `PS24_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (!busy && !out_valid))

endmodule
`default_nettype wire

// ===== verif/ps24_key_checker.sv =====
// Channel monitor, round key predictor and comparator for the key schedule.
module ps24_key_checker (
  input  logic clk,
  input  logic rst,
  ps24_key_if  key_mon,
  ps24_sub_if  sub_mon,
  output int   fail_count,
  output int   pending
);
  import ps24_pkg::*;

  typedef struct packed {
    logic [SUBKEY_W-1:0] subkey;
    logic [ROUND_W-1:0]  round_number;
    logic                last_subkey;
  } round_key_t;

  localparam logic [3:0] PRESENT_SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  round_key_t round_keys_due [$];

  // Rotate left by 61, pass the top nibble through the S-box, fold in the round.
  function automatic logic [KEY_W-1:0] advance_key(input logic [KEY_W-1:0] k,
                                                   input logic [MIX_W-1:0] rnd);
    logic [KEY_W-1:0] n;
    n = {k[ROT_RIGHT-1:0], k[KEY_W-1:ROT_RIGHT]};
    n[KEY_W-1 -: 4] = PRESENT_SBOX[n[KEY_W-1 -: 4]];
    n[MIX_LSB +: MIX_W] = n[MIX_LSB +: MIX_W] ^ rnd;
    return n;
  endfunction

  function automatic int field_mismatch(input string field, input logic [SUBKEY_W-1:0] want,
                                        input logic [SUBKEY_W-1:0] seen);
    if (seen === want) return 0;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    logic [KEY_W-1:0] key_reg;
    round_key_t       due;
    round_key_t       got;
    int               errs;
    errs = 0;
    if (rst) begin
      round_keys_due.delete();
      fail_count <= 0;
    end else begin
      // Compare first: a subkey leaving now belongs to an earlier master key.
      if (sub_mon.valid && sub_mon.ready) begin
        got = '{sub_mon.subkey, sub_mon.round_number, sub_mon.last_subkey};
        if (round_keys_due.size() == 0) begin
          errs = 1;
          $display("%0t: unexpected subkey, expected none, actual %h round %0d last %b",
                   $time, got.subkey, got.round_number, got.last_subkey);
        end else begin
          due = round_keys_due.pop_front();
          if (field_mismatch("subkey", due.subkey, got.subkey) +
              field_mismatch("round_number", SUBKEY_W'(due.round_number),
                             SUBKEY_W'(got.round_number)) +
              field_mismatch("last_subkey", SUBKEY_W'(due.last_subkey),
                             SUBKEY_W'(got.last_subkey)) != 0)
            errs = 1;
        end
      end
      if (key_mon.valid && key_mon.ready) begin
        key_reg = {key_mon.master_key, {(KEY_W-MASTER_W){1'b0}}};
        for (int r = 1; r <= NUM_SUBKEYS; r++) begin
          due.subkey       = key_reg[SUBKEY_LSB +: SUBKEY_W];
          due.round_number = ROUND_W'(r - 1);
          due.last_subkey  = (r == NUM_SUBKEYS);
          round_keys_due.push_back(due);
          key_reg = advance_key(key_reg, MIX_W'(r));
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= round_keys_due.size();
  end

endmodule

// ===== verif/tb_present24_key_schedule.sv =====
// Testbench top: clock, reset, master key stimulus, output back-pressure and verdict.
module tb_present24_key_schedule;
  import ps24_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;

  ps24_key_if key_ch ();
  ps24_sub_if sub_ch ();

  present24_key_schedule dut (
    .clk     (clk),
    .rst     (rst),
    .key_in  (key_ch),
    .sub_out (sub_ch)
  );

  ps24_key_checker key_chk (
    .clk        (clk),
    .rst        (rst),
    .key_mon    (key_ch),
    .sub_mon    (sub_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  localparam logic [MASTER_W-1:0] EDGE_KEYS [14] = '{
    24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, 24'h7FFFFF, 24'hFFFFFE, 24'hAAAAAA,
    24'h555555, 24'h0000FF, 24'hFFFF00, 24'h00FF00, 24'hF0F0F0, 24'h0F0F0F, 24'h123456
  };

  always #10 clk = ~clk;

  // Hold the key on the channel until the transaction completes.
  task automatic offer_key(input logic [MASTER_W-1:0] mk, input int gap);
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.valid      <= 1'b1;
    key_ch.master_key <= mk;
    do @(posedge clk); while (!key_ch.ready);
  endtask

  // Drop valid and wait until every predicted subkey has been seen.
  task automatic drain();
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int gap;
    key_ch.valid      = 1'b0;
    key_ch.master_key = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (EDGE_KEYS[i])
      offer_key(EDGE_KEYS[i], (i < 5) ? 0 : $urandom_range(0, 17));
    drain();
    for (int i = 0; i < 130; i++) begin
      gap = (i >= 40 && i < 70) ? 0 : $urandom_range(0, 17);
      offer_key(MASTER_W'($urandom), gap);
      if (i == 90) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : subkey_sink
    int stall;
    int taken;
    taken        = 0;
    sub_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      // Hold off long enough to fill the block and stall its input.
      if (taken == 60) stall = 400;
      else if (taken >= 250 && taken < 450) stall = 0;
      else stall = $urandom_range(0, 17);
      if (stall > 0) begin
        sub_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sub_ch.ready <= 1'b1;
      do @(posedge clk); while (!sub_ch.valid);
      taken++;
    end
  end

  initial begin : watchdog
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
